[rtl/http_request_field_locator_assert.svh]
// Assertion macros for the RTL of the HTTP request field locator.
`ifndef HTTP_REQUEST_FIELD_LOCATOR_ASSERT_SVH
`define HTTP_REQUEST_FIELD_LOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define HRFL_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hrfl assertion failed (same cycle)");
// Next-cycle implication, checked outside reset.
`define HRFL_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hrfl assertion failed (next cycle)");
`else
`define HRFL_ASSERT_IMP(name, clk, rstn, ante, cons)
`define HRFL_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif

`endif

[rtl/hrfl_pkg.sv]
package hrfl_pkg;

  localparam int MAX_LEN = 16384;
  // Byte position must be able to hold MAX_LEN itself.
  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam int FLD_W = 14;

  localparam int NUM_METH = 4;
  localparam logic [1:0] METH_POST = 2'd0;
  localparam logic [1:0] METH_GET  = 2'd1;
  localparam logic [1:0] METH_PUT  = 2'd2;
  localparam logic [1:0] METH_HEAD = 2'd3;

  localparam int VER_LEN = 7;
  localparam logic [8*VER_LEN-1:0] VER_PAT = 56'h48_54_54_50_2F_31_2E;

  localparam int HOST_LEN  = 6;
  localparam int AGENT_LEN = 12;
  localparam int HOST_IW   = $clog2(HOST_LEN);
  localparam int AGENT_IW  = $clog2(AGENT_LEN);

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] length;
  } hdr_rec_t;

  function automatic logic [31:0] meth_pat(input logic [1:0] m);
    case (m)
      METH_POST: meth_pat = 32'h50_4F_53_54;
      METH_GET:  meth_pat = 32'h00_47_45_54;
      METH_PUT:  meth_pat = 32'h00_50_55_54;
      METH_HEAD: meth_pat = 32'h48_45_41_44;
      default:   meth_pat = 32'h0;
    endcase
  endfunction

  function automatic logic [2:0] meth_len(input logic [1:0] m);
    case (m)
      METH_POST: meth_len = 3'd4;
      METH_HEAD: meth_len = 3'd4;
      default:   meth_len = 3'd3;
    endcase
  endfunction

  function automatic logic meth_hit(input logic [1:0] m, input logic [31:0] tail);
    logic [31:0] mask;
    mask = (meth_len(m) == 3'd4) ? 32'hFFFF_FFFF : 32'h00FF_FFFF;
    meth_hit = ((tail & mask) == meth_pat(m));
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    to_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] host_char(input logic [HOST_IW-1:0] k);
    case (k)
      3'd0:    host_char = 8'h68;
      3'd1:    host_char = 8'h6F;
      3'd2:    host_char = 8'h73;
      3'd3:    host_char = 8'h74;
      3'd4:    host_char = 8'h3A;
      3'd5:    host_char = 8'h20;
      default: host_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] agent_char(input logic [AGENT_IW-1:0] k);
    case (k)
      4'd0:    agent_char = 8'h75;
      4'd1:    agent_char = 8'h73;
      4'd2:    agent_char = 8'h65;
      4'd3:    agent_char = 8'h72;
      4'd4:    agent_char = 8'h2D;
      4'd5:    agent_char = 8'h61;
      4'd6:    agent_char = 8'h67;
      4'd7:    agent_char = 8'h65;
      4'd8:    agent_char = 8'h6E;
      4'd9:    agent_char = 8'h74;
      4'd10:   agent_char = 8'h3A;
      4'd11:   agent_char = 8'h20;
      default: agent_char = 8'h00;
    endcase
  endfunction

endpackage

[rtl/hrfl_if.sv]
interface hrfl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hrfl_out_if;
  logic                       valid;
  logic                       ready;
  logic                       request_found;
  logic [1:0]                 method_code;
  logic [hrfl_pkg::FLD_W-1:0] path_start;
  logic [hrfl_pkg::FLD_W-1:0] path_length;
  logic                       host_found;
  logic [hrfl_pkg::FLD_W-1:0] host_start;
  logic [hrfl_pkg::FLD_W-1:0] host_length;
  logic                       agent_found;
  logic [hrfl_pkg::FLD_W-1:0] agent_start;
  logic [hrfl_pkg::FLD_W-1:0] agent_length;
  logic                       overflow;

  modport source (
    output valid, input ready,
    output request_found, output method_code, output path_start, output path_length,
    output host_found, output host_start, output host_length,
    output agent_found, output agent_start, output agent_length, output overflow
  );
  modport sink (
    input valid, output ready,
    input request_found, input method_code, input path_start, input path_length,
    input host_found, input host_start, input host_length,
    input agent_found, input agent_start, input agent_length, input overflow
  );
endinterface

[rtl/http_request_field_locator.sv]
// HTTP request field locator.
// in_bus carries one packet byte per beat with last_byte set on the final
// byte. For each packet, out_bus delivers exactly one beat carrying the
// method code, path offset/length and host and user-agent value offsets and
// lengths, or the overflow flag for packets longer than MAX_LEN bytes.
// Throughput is one byte per cycle while in_bus.ready is high: the per-byte
// matchers and the line tracker update in the cycle a byte is accepted. The
// last byte of a packet is latched into a finishing register; once the
// output register is free, the method priority and path bounds are resolved
// into it and the result beat becomes valid.
// Reset (synchronous, active low) clears the scan state and empties both the
// finishing and output registers. If the receiver stalls, the result waits
// in the output register while the next packet keeps streaming in; input
// ready drops only when a second finished packet is waiting behind it.
module http_request_field_locator (
  input  logic       clk,
  input  logic       rst_n,
  hrfl_in_if.sink    in_bus,
  hrfl_out_if.source out_bus
);

  localparam int PW = hrfl_pkg::POS_W;

  // Scan state.
  logic [PW-1:0]                 pos_r, pos_nxt;
  logic [55:0]                   rb_r, rb_nxt;
  logic [3:0]                    mok_r, mok_nxt;
  logic [3:0][PW-1:0]            mpos_r, mpos_nxt;
  logic [3:0]                    snap_ok_r, snap_ok_nxt;
  logic [3:0][PW-1:0]            snap_pos_r, snap_pos_nxt;
  logic                          ver_ok_r, ver_ok_nxt;
  logic [PW-1:0]                 ver_pos_r, ver_pos_nxt;
  logic [PW-1:0]                 lp_r, lp_nxt;
  logic                          host_alive_r, host_alive_nxt;
  logic                          agent_alive_r, agent_alive_nxt;
  hrfl_pkg::hdr_rec_t            host_rec_r, host_rec_nxt;
  hrfl_pkg::hdr_rec_t            agent_rec_r, agent_rec_nxt;
  logic                          ovf_r, ovf_nxt;

  // Finishing register, loaded from the last byte of a packet.
  logic                          fin_valid_r, fin_valid_nxt;
  logic                          fin_ovf_r;
  logic                          fin_ver_ok_r;
  logic [PW-1:0]                 fin_ver_pos_r;
  logic [3:0]                    fin_snap_ok_r;
  logic [3:0][PW-1:0]            fin_snap_pos_r;
  hrfl_pkg::hdr_rec_t            fin_host_r;
  hrfl_pkg::hdr_rec_t            fin_agent_r;

  // Output register.
  logic                          out_valid_r, out_valid_nxt;
  logic                          o_req_r, o_req_nxt;
  logic [1:0]                    o_meth_r, o_meth_nxt;
  logic [hrfl_pkg::FLD_W-1:0]    o_pstart_r, o_pstart_nxt;
  logic [hrfl_pkg::FLD_W-1:0]    o_plen_r, o_plen_nxt;
  logic                          o_hfound_r, o_hfound_nxt;
  logic [hrfl_pkg::FLD_W-1:0]    o_hstart_r, o_hstart_nxt;
  logic [hrfl_pkg::FLD_W-1:0]    o_hlen_r, o_hlen_nxt;
  logic                          o_afound_r, o_afound_nxt;
  logic [hrfl_pkg::FLD_W-1:0]    o_astart_r, o_astart_nxt;
  logic [hrfl_pkg::FLD_W-1:0]    o_alen_r, o_alen_nxt;
  logic                          o_ovf_r, o_ovf_nxt;

  logic          fin_adv;
  logic          in_ready;
  logic          in_acc;
  logic          fin_load;
  logic [7:0]    byte_c;
  logic [7:0]    lc;
  logic          skip;
  logic          term;
  logic          ver_hit;
  logic [55:0]   rb_shift;
  logic          host_step;
  logic          agent_step;
  logic [PW-1:0] line_start;
  logic [PW-1:0] eff_lp;
  logic          h_alive_eff;
  logic          a_alive_eff;
  logic          end_evt;

  assign fin_adv  = fin_valid_r && (!out_valid_r || out_bus.ready);
  assign in_ready = !fin_valid_r || fin_adv;
  assign in_acc   = in_bus.valid && in_ready;
  assign fin_load = in_acc && in_bus.last_byte;
  assign in_bus.ready = in_ready;

  assign byte_c   = in_bus.data_byte;
  assign lc       = hrfl_pkg::to_lower(byte_c);
  assign skip     = ovf_r || (pos_r >= PW'(hrfl_pkg::MAX_LEN));
  assign term     = (byte_c == hrfl_pkg::CH_NUL) || (byte_c == hrfl_pkg::CH_LF) ||
                    (byte_c == hrfl_pkg::CH_CR);
  assign rb_shift = {rb_r[47:0], byte_c};
  assign ver_hit  = (rb_shift == hrfl_pkg::VER_PAT);

  // Header name prefix trackers; past the prefix the alive flag just holds.
  always_comb begin
    if (lp_r >= PW'(hrfl_pkg::HOST_LEN)) begin
      host_step = host_alive_r;
    end else begin
      host_step = ((lp_r == '0) || host_alive_r) &&
                  (lc == hrfl_pkg::host_char(lp_r[hrfl_pkg::HOST_IW-1:0]));
    end
    if (lp_r >= PW'(hrfl_pkg::AGENT_LEN)) begin
      agent_step = agent_alive_r;
    end else begin
      agent_step = ((lp_r == '0) || agent_alive_r) &&
                   (lc == hrfl_pkg::agent_char(lp_r[hrfl_pkg::AGENT_IW-1:0]));
    end
  end

  // A line closes on a terminator, or at packet end with the last byte
  // counted in. Either way the line began at pos_r - lp_r.
  assign line_start  = pos_r - lp_r;
  assign eff_lp      = term ? lp_r : lp_r + PW'(1);
  assign h_alive_eff = term ? host_alive_r : host_step;
  assign a_alive_eff = term ? agent_alive_r : agent_step;
  assign end_evt     = ver_ok_r && !ver_hit && (term || in_bus.last_byte);

  always_comb begin
    pos_nxt         = pos_r;
    rb_nxt          = rb_r;
    mok_nxt         = mok_r;
    mpos_nxt        = mpos_r;
    snap_ok_nxt     = snap_ok_r;
    snap_pos_nxt    = snap_pos_r;
    ver_ok_nxt      = ver_ok_r;
    ver_pos_nxt     = ver_pos_r;
    lp_nxt          = lp_r;
    host_alive_nxt  = host_alive_r;
    agent_alive_nxt = agent_alive_r;
    host_rec_nxt    = host_rec_r;
    agent_rec_nxt   = agent_rec_r;
    ovf_nxt         = ovf_r;
    if (in_acc) begin
      if (skip) begin
        ovf_nxt = 1'b1;
      end else begin
        rb_nxt = rb_shift;
        for (int i = 0; i < hrfl_pkg::NUM_METH; i++) begin
          if (hrfl_pkg::meth_hit(2'(i), rb_shift[31:0])) begin
            mok_nxt[i]  = 1'b1;
            mpos_nxt[i] = pos_r + PW'(1) - PW'(hrfl_pkg::meth_len(2'(i)));
          end
        end
        if (ver_ok_r) begin
          if (term) begin
            lp_nxt          = '0;
            host_alive_nxt  = 1'b0;
            agent_alive_nxt = 1'b0;
          end else begin
            host_alive_nxt  = host_step;
            agent_alive_nxt = agent_step;
            lp_nxt          = lp_r + PW'(1);
          end
        end
        if (end_evt) begin
          if (!host_rec_r.found && h_alive_eff && eff_lp >= PW'(hrfl_pkg::HOST_LEN)) begin
            host_rec_nxt.found  = 1'b1;
            host_rec_nxt.start  = line_start + PW'(hrfl_pkg::HOST_LEN);
            host_rec_nxt.length = eff_lp - PW'(hrfl_pkg::HOST_LEN);
          end
          if (!agent_rec_r.found && a_alive_eff && eff_lp >= PW'(hrfl_pkg::AGENT_LEN)) begin
            agent_rec_nxt.found  = 1'b1;
            agent_rec_nxt.start  = line_start + PW'(hrfl_pkg::AGENT_LEN);
            agent_rec_nxt.length = eff_lp - PW'(hrfl_pkg::AGENT_LEN);
          end
        end
        if (ver_hit) begin
          ver_ok_nxt      = 1'b1;
          ver_pos_nxt     = pos_r + PW'(1) - PW'(hrfl_pkg::VER_LEN);
          snap_ok_nxt     = mok_nxt;
          snap_pos_nxt    = mpos_nxt;
          lp_nxt          = PW'(hrfl_pkg::VER_LEN);
          host_alive_nxt  = 1'b0;
          agent_alive_nxt = 1'b0;
          host_rec_nxt    = '0;
          agent_rec_nxt   = '0;
        end
        pos_nxt = pos_r + PW'(1);
      end
    end
  end

  // The scan state restarts after the last byte; its final values go to
  // the finishing register instead.
  always_ff @(posedge clk) begin
    if (!rst_n || fin_load) begin
      pos_r         <= '0;
      rb_r          <= '0;
      mok_r         <= '0;
      mpos_r        <= '0;
      snap_ok_r     <= '0;
      snap_pos_r    <= '0;
      ver_ok_r      <= 1'b0;
      ver_pos_r     <= '0;
      lp_r          <= '0;
      host_alive_r  <= 1'b0;
      agent_alive_r <= 1'b0;
      host_rec_r    <= '0;
      agent_rec_r   <= '0;
      ovf_r         <= 1'b0;
    end else begin
      pos_r         <= pos_nxt;
      rb_r          <= rb_nxt;
      mok_r         <= mok_nxt;
      mpos_r        <= mpos_nxt;
      snap_ok_r     <= snap_ok_nxt;
      snap_pos_r    <= snap_pos_nxt;
      ver_ok_r      <= ver_ok_nxt;
      ver_pos_r     <= ver_pos_nxt;
      lp_r          <= lp_nxt;
      host_alive_r  <= host_alive_nxt;
      agent_alive_r <= agent_alive_nxt;
      host_rec_r    <= host_rec_nxt;
      agent_rec_r   <= agent_rec_nxt;
      ovf_r         <= ovf_nxt;
    end
  end

  assign fin_valid_nxt = fin_load || (fin_valid_r && !fin_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else begin
      fin_valid_r <= fin_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      fin_ovf_r      <= ovf_nxt;
      fin_ver_ok_r   <= ver_ok_nxt;
      fin_ver_pos_r  <= ver_pos_nxt;
      fin_snap_ok_r  <= snap_ok_nxt;
      fin_snap_pos_r <= snap_pos_nxt;
      fin_host_r     <= host_rec_nxt;
      fin_agent_r    <= agent_rec_nxt;
    end
  end

  // Method priority and path bounds. Only the highest-priority method seen
  // before the version mark counts, even when its path turns out empty.
  always_comb begin
    logic          any_ok;
    logic [1:0]    sel;
    logic [PW:0]   ps;
    logic [PW:0]   stop;
    logic          req;
    any_ok = |fin_snap_ok_r;
    sel    = hrfl_pkg::METH_HEAD;
    for (int i = hrfl_pkg::NUM_METH - 1; i >= 0; i--) begin
      if (fin_snap_ok_r[i]) begin
        sel = 2'(i);
      end
    end
    ps   = {1'b0, fin_snap_pos_r[sel]} + (PW+1)'(hrfl_pkg::meth_len(sel)) + (PW+1)'(1);
    stop = {1'b0, fin_ver_pos_r} - (PW+1)'(1);
    req  = !fin_ovf_r && fin_ver_ok_r && any_ok && (fin_ver_pos_r != '0) && (stop > ps);

    o_req_nxt    = req;
    o_meth_nxt   = req ? sel : 2'd0;
    o_pstart_nxt = req ? ps[hrfl_pkg::FLD_W-1:0] : '0;
    o_plen_nxt   = req ? stop[hrfl_pkg::FLD_W-1:0] - ps[hrfl_pkg::FLD_W-1:0] : '0;
    o_hfound_nxt = req && fin_host_r.found;
    o_hstart_nxt = o_hfound_nxt ? fin_host_r.start[hrfl_pkg::FLD_W-1:0] : '0;
    o_hlen_nxt   = o_hfound_nxt ? fin_host_r.length[hrfl_pkg::FLD_W-1:0] : '0;
    o_afound_nxt = req && fin_agent_r.found;
    o_astart_nxt = o_afound_nxt ? fin_agent_r.start[hrfl_pkg::FLD_W-1:0] : '0;
    o_alen_nxt   = o_afound_nxt ? fin_agent_r.length[hrfl_pkg::FLD_W-1:0] : '0;
    o_ovf_nxt    = fin_ovf_r;
  end

  assign out_valid_nxt = fin_adv || (out_valid_r && !out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_adv) begin
      o_req_r    <= o_req_nxt;
      o_meth_r   <= o_meth_nxt;
      o_pstart_r <= o_pstart_nxt;
      o_plen_r   <= o_plen_nxt;
      o_hfound_r <= o_hfound_nxt;
      o_hstart_r <= o_hstart_nxt;
      o_hlen_r   <= o_hlen_nxt;
      o_afound_r <= o_afound_nxt;
      o_astart_r <= o_astart_nxt;
      o_alen_r   <= o_alen_nxt;
      o_ovf_r    <= o_ovf_nxt;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.request_found = o_req_r;
  assign out_bus.method_code   = o_meth_r;
  assign out_bus.path_start    = o_pstart_r;
  assign out_bus.path_length   = o_plen_r;
  assign out_bus.host_found    = o_hfound_r;
  assign out_bus.host_start    = o_hstart_r;
  assign out_bus.host_length   = o_hlen_r;
  assign out_bus.agent_found   = o_afound_r;
  assign out_bus.agent_start   = o_astart_r;
  assign out_bus.agent_length  = o_alen_r;
  assign out_bus.overflow      = o_ovf_r;

`include "http_request_field_locator_assert.svh"

  `HRFL_ASSERT_NXT(a_last_fills_fin, clk, rst_n, fin_load, fin_valid_r)
  `HRFL_ASSERT_NXT(a_fin_holds, clk, rst_n, fin_valid_r && !fin_adv, fin_valid_r && $stable(fin_ovf_r))
  `HRFL_ASSERT_IMP(a_ovf_alone, clk, rst_n, out_valid_r && o_ovf_r, !o_req_r && !o_hfound_r && !o_afound_r)
  `HRFL_ASSERT_IMP(a_hdr_needs_req, clk, rst_n, out_valid_r && (o_hfound_r || o_afound_r), o_req_r)

endmodule
